// ===== rtl/core/ffra_pkg.sv =====
// Shared types and constants of the first-fit range allocator.
package ffra_pkg;

   localparam int SEG_DEPTH = 64;
   localparam int IDX_W     = $clog2(SEG_DEPTH);
   localparam int CNT_W     = IDX_W + 1;
   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = ADDR_W + 1;
   localparam int WIDE_W    = ADDR_W + 2;

   localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_W;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] CSR_POOL  = 2'd0;
   localparam logic [1:0] CSR_ALIGN = 2'd1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] len;
   } seg_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      seg_type          wdata;
      logic [IDX_W-1:0] raddr;
   } tbl_req_type;

   typedef struct packed {
      logic              init;
      logic [SIZE_W-1:0] pool;
      logic [4:0]        align_log2;
   } cfg_type;

endpackage

// ===== rtl/core/ffra_seg_table.sv =====
// Segment table memory: one write port, one registered read port.
module ffra_seg_table (
   input  logic                  clock,
   input  ffra_pkg::tbl_req_type tbl_req,
   output ffra_pkg::seg_type     rd_data
);

   ffra_pkg::seg_type mem [ffra_pkg::SEG_DEPTH];
   ffra_pkg::seg_type rd_data_ff;

   // Write one entry, read one entry
   always_ff @(posedge clock) begin
      if (tbl_req.we) begin
         mem[tbl_req.waddr] <= tbl_req.wdata;
      end
      rd_data_ff <= mem[tbl_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ffra_ctrl.sv =====
// Sequencer that walks, updates and shifts the segment table.
module ffra_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [ffra_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [ffra_pkg::ADDR_W-1:0]   req_block_offset,
   input  ffra_pkg::cfg_type             cfg,
   output ffra_pkg::tbl_req_type         tbl_req,
   input  ffra_pkg::seg_type             rd_data,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [ffra_pkg::ADDR_W-1:0]   rsp_granted_offset,
   output logic [ffra_pkg::SIZE_W-1:0]   rsp_granted_size
);

   typedef enum logic [2:0] {
      S_IDLE, S_A_WALK, S_F_WALK, S_DECIDE, S_SHIFT_DN, S_SHIFT_UP, S_INS
   } state_type;

   state_type state_ff, state_in;
   logic [ffra_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ffra_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [ffra_pkg::CNT_W-1:0]  pos_ff, pos_in;
   logic [ffra_pkg::SIZE_W-1:0] len_ff, len_in;
   logic [ffra_pkg::ADDR_W-1:0] off_ff, off_in;
   logic [ffra_pkg::WIDE_W-1:0] aligned_ff, aligned_in;
   ffra_pkg::seg_type           prev_ff, prev_in, next_ff, next_in;
   logic                        have_prev_ff, have_prev_in, have_next_ff, have_next_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [ffra_pkg::ADDR_W-1:0] rsp_off_ff, rsp_off_in;
   logic [ffra_pkg::SIZE_W-1:0] rsp_size_ff, rsp_size_in;

   logic [ffra_pkg::WIDE_W-1:0] unit, amask, req_end, prev_tail, free_end;
   logic [ffra_pkg::CNT_W-1:0]  idx_next, idx_prev, count_last;
   logic                        mprev, mnext;

   assign busy       = (state_ff != S_IDLE);
   assign idx_next   = idx_ff + ffra_pkg::CNT_W'(1);
   assign idx_prev   = idx_ff - ffra_pkg::CNT_W'(1);
   assign count_last = count_ff - ffra_pkg::CNT_W'(1);

   // Round the request up and form the range ends
   assign unit      = ffra_pkg::WIDE_W'(1) << cfg.align_log2;
   assign amask     = unit - ffra_pkg::WIDE_W'(1);
   assign req_end   = ffra_pkg::WIDE_W'(req_block_offset) + ffra_pkg::WIDE_W'(req_request_size);
   assign free_end  = ffra_pkg::WIDE_W'(off_ff) + ffra_pkg::WIDE_W'(len_ff);
   assign prev_tail = ffra_pkg::WIDE_W'(prev_ff.start) + ffra_pkg::WIDE_W'(prev_ff.len);
   assign mprev     = have_prev_ff && (prev_tail == ffra_pkg::WIDE_W'(off_ff));
   assign mnext     = have_next_ff && (free_end == ffra_pkg::WIDE_W'(next_ff.start));

   // Sequence one operation
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      off_in        = off_ff;
      aligned_in    = aligned_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      have_prev_in  = have_prev_ff;
      have_next_in  = have_next_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_size_in   = rsp_size_ff;
      tbl_req.we    = 1'b0;
      tbl_req.waddr = idx_ff[ffra_pkg::IDX_W-1:0];
      tbl_req.wdata = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (cfg.init) begin
               tbl_req.we    = 1'b1;
               tbl_req.waddr = '0;
               tbl_req.wdata = '{start: '0, len: cfg.pool};
               count_in      = (cfg.pool != '0) ? ffra_pkg::CNT_W'(1) : '0;
            end else if (start) begin
               len_in       = req_request_size;
               off_in       = req_block_offset;
               idx_in       = '0;
               have_prev_in = 1'b0;
               have_next_in = 1'b0;
               if ((ffra_pkg::WIDE_W'(req_request_size) & amask) == '0) begin
                  aligned_in = ffra_pkg::WIDE_W'(req_request_size);
               end else begin
                  aligned_in = (ffra_pkg::WIDE_W'(req_request_size) & ~amask) + unit;
               end
               if (req_operation == ffra_pkg::OP_ALLOC) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ffra_pkg::ST_NOFIT;
                     rsp_off_in    = '0;
                     rsp_size_in   = '0;
                  end else begin
                     state_in = S_A_WALK;
                  end
               end else if (req_request_size == '0 ||
                            req_end > ffra_pkg::WIDE_W'(cfg.pool)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffra_pkg::ST_INVALID;
                  rsp_off_in    = '0;
                  rsp_size_in   = '0;
               end else if (count_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_F_WALK;
               end
            end
         end

         S_A_WALK: begin
            if (rd_data.len >= len_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffra_pkg::ST_OK;
               rsp_off_in    = rd_data.start;
               if (ffra_pkg::WIDE_W'(rd_data.len) > aligned_ff) begin
                  // Split the front off the segment
                  tbl_req.we    = 1'b1;
                  tbl_req.wdata = '{start: rd_data.start + aligned_ff[ffra_pkg::ADDR_W-1:0],
                                    len:   rd_data.len - aligned_ff[ffra_pkg::SIZE_W-1:0]};
                  rsp_size_in   = aligned_ff[ffra_pkg::SIZE_W-1:0];
                  state_in      = S_IDLE;
               end else begin
                  // Grant the whole segment and drop it
                  rsp_size_in = rd_data.len;
                  if (idx_ff == count_last) begin
                     count_in = count_last;
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_next;
                     state_in = S_SHIFT_DN;
                  end
               end
            end else if (idx_next == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffra_pkg::ST_NOFIT;
               rsp_off_in    = '0;
               rsp_size_in   = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end

         S_F_WALK: begin
            if (rd_data.start < off_ff) begin
               prev_in      = rd_data;
               have_prev_in = 1'b1;
               idx_in       = idx_next;
               if (idx_next == count_ff) begin
                  state_in = S_DECIDE;
               end
            end else begin
               next_in      = rd_data;
               have_next_in = 1'b1;
               state_in     = S_DECIDE;
            end
         end

         S_DECIDE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ffra_pkg::ST_OK;
            rsp_off_in    = '0;
            rsp_size_in   = '0;
            state_in      = S_IDLE;
            if ((have_prev_ff && prev_tail > ffra_pkg::WIDE_W'(off_ff)) ||
                (have_next_ff && free_end > ffra_pkg::WIDE_W'(next_ff.start))) begin
               rsp_status_in = ffra_pkg::ST_INVALID;
            end else if (mprev && mnext) begin
               // Merge both neighbors, then close the gap
               tbl_req.we    = 1'b1;
               tbl_req.waddr = idx_prev[ffra_pkg::IDX_W-1:0];
               tbl_req.wdata = '{start: prev_ff.start,
                                 len:   prev_ff.len + len_ff + next_ff.len};
               if (idx_ff == count_last) begin
                  count_in = count_last;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_SHIFT_DN;
               end
            end else if (mprev) begin
               tbl_req.we    = 1'b1;
               tbl_req.waddr = idx_prev[ffra_pkg::IDX_W-1:0];
               tbl_req.wdata = '{start: prev_ff.start, len: prev_ff.len + len_ff};
            end else if (mnext) begin
               tbl_req.we    = 1'b1;
               tbl_req.wdata = '{start: off_ff, len: next_ff.len + len_ff};
            end else if (count_ff == ffra_pkg::CNT_W'(ffra_pkg::SEG_DEPTH)) begin
               rsp_status_in = ffra_pkg::ST_FULL;
            end else if (idx_ff == count_ff) begin
               tbl_req.we    = 1'b1;
               tbl_req.wdata = '{start: off_ff, len: len_ff};
               count_in      = count_ff + ffra_pkg::CNT_W'(1);
            end else begin
               // Open a slot by moving the tail up
               pos_in   = idx_ff;
               idx_in   = count_last;
               state_in = S_SHIFT_UP;
            end
         end

         S_SHIFT_DN: begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = idx_prev[ffra_pkg::IDX_W-1:0];
            if (idx_ff == count_last) begin
               count_in = count_last;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end

         S_SHIFT_UP: begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = idx_next[ffra_pkg::IDX_W-1:0];
            if (idx_ff == pos_ff) begin
               state_in = S_INS;
            end else begin
               idx_in = idx_prev;
            end
         end

         S_INS: begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = pos_ff[ffra_pkg::IDX_W-1:0];
            tbl_req.wdata = '{start: off_ff, len: len_ff};
            count_in      = count_ff + ffra_pkg::CNT_W'(1);
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      tbl_req.raddr = idx_in[ffra_pkg::IDX_W-1:0];
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      len_ff        <= len_in;
      off_ff        <= off_in;
      aligned_ff    <= aligned_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      have_prev_ff  <= have_prev_in;
      have_next_ff  <= have_next_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_off_ff;
   assign rsp_granted_size   = rsp_size_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ffra_pkg::CNT_W'(ffra_pkg::SEG_DEPTH))
      else $error("segment count exceeds table depth");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !cfg.init |=> busy || rsp_valid)
      else $error("accepted item neither started nor answered");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy raised without a request");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT_DN |-> idx_ff < count_ff)
      else $error("shift read beyond table fill");
`endif

endmodule

// ===== rtl/core/first_fit_range_allocator.sv =====
// Top level: CSR port, config registers and the allocator core.
// An allocate walks the table to the first segment that fits; a free that is not rejected at once
// walks to its place in address order, then merges or inserts.
// Busy may stay high after the result while the table shifts; items run one at a time.
// Results last one cycle; no receiver stall.
// Synchronous active-high reset empties the table and clears pool size and alignment.
module first_fit_range_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [ffra_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [ffra_pkg::ADDR_W-1:0]   req_block_offset,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [ffra_pkg::ADDR_W-1:0]   rsp_granted_offset,
   output logic [ffra_pkg::SIZE_W-1:0]   rsp_granted_size,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [ffra_pkg::SIZE_W-1:0]   csr_wdata
);

   logic [ffra_pkg::SIZE_W-1:0] pool_ff, pool_in, pool_sat;
   logic [4:0]                  align_ff, align_in;
   logic                        csr_beat;
   ffra_pkg::cfg_type           cfg;
   ffra_pkg::tbl_req_type       tbl_req;
   ffra_pkg::seg_type           rd_data;

   // Take a CSR beat only when no item is running or being offered
   assign csr_ready = !busy && !start;
   assign csr_beat  = csr_valid && csr_ready;
   assign pool_sat  = (csr_wdata > ffra_pkg::POOL_MAX) ? ffra_pkg::POOL_MAX : csr_wdata;

   // Decode a CSR beat
   always_comb begin
      pool_in  = pool_ff;
      align_in = align_ff;
      cfg.init = 1'b0;
      if (csr_beat) begin
         case (csr_index)
            ffra_pkg::CSR_POOL: begin
               pool_in  = pool_sat;
               cfg.init = 1'b1;
            end
            ffra_pkg::CSR_ALIGN: begin
               align_in = csr_wdata[4:0];
            end
            default: begin
            end
         endcase
      end
      cfg.pool       = pool_in;
      cfg.align_log2 = align_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff  <= '0;
         align_ff <= '0;
      end else begin
         pool_ff  <= pool_in;
         align_ff <= align_in;
      end
   end

   ffra_seg_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (rd_data)
   );

   ffra_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_request_size   (req_request_size),
      .req_block_offset   (req_block_offset),
      .cfg                (cfg),
      .tbl_req            (tbl_req),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_granted_size   (rsp_granted_size)
   );

endmodule

// ===== tb/tb_first_fit_range_allocator.sv =====
// Self-checking testbench of the first-fit range allocator: directed and random allocate/free.
`timescale 1ns / 100ps

module tb_first_fit_range_allocator;

   localparam int   DRAIN_CYCLES = 140;

   typedef struct packed {
      logic [1:0]                  status;
      logic [ffra_pkg::ADDR_W-1:0] offset;
      logic [ffra_pkg::SIZE_W-1:0] size;
   } grant_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_operation = 1'b0;
   logic [ffra_pkg::SIZE_W-1:0]   req_request_size = '0;
   logic [ffra_pkg::ADDR_W-1:0]   req_block_offset = '0;
   logic                          rsp_valid;
   logic [1:0]                    rsp_status;
   logic [ffra_pkg::ADDR_W-1:0]   rsp_granted_offset;
   logic [ffra_pkg::SIZE_W-1:0]   rsp_granted_size;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [1:0]                    csr_index = '0;
   logic [ffra_pkg::SIZE_W-1:0]   csr_wdata = '0;

   // free-segment table mirror
   longint unsigned free_start [ffra_pkg::SEG_DEPTH];
   longint unsigned free_len   [ffra_pkg::SEG_DEPTH];
   int              free_count;
   longint unsigned pool_len;
   int unsigned     align_sh;

   grant_type       pending_grants[$];
   longint unsigned held_off[$];
   longint unsigned held_len[$];
   int              errors = 0;
   int              gap_pct = 30;

   first_fit_range_allocator u_top (.*);

   always #1 clock = ~clock;

   // rebuild the table from the pool size
   function automatic void clear_table();
      for (int k = 0; k < ffra_pkg::SEG_DEPTH; k++) begin
         free_start[k] = 0;
         free_len[k] = 0;
      end
      free_count = 0;
      if (pool_len != 0) begin
         free_len[0] = pool_len;
         free_count = 1;
      end
   endfunction

   function automatic void remove_seg(int at);
      for (int k = at; k < free_count - 1; k++) begin
         free_start[k] = free_start[k+1];
         free_len[k] = free_len[k+1];
      end
      free_count--;
      free_start[free_count] = 0;
      free_len[free_count] = 0;
   endfunction

   function automatic grant_type allocate_range(longint unsigned req);
      grant_type g;
      longint unsigned unit, mask, aligned, off, len;
      unit = 64'd1 << align_sh;
      mask = unit - 1;
      aligned = ((req & mask) == 0) ? req : (req & ~mask) + unit;
      g = '{status: ffra_pkg::ST_NOFIT, offset: '0, size: '0};
      for (int k = 0; k < free_count; k++) begin
         if (free_len[k] >= req) begin
            off = free_start[k];
            if (free_len[k] > aligned) begin
               free_start[k] += aligned;
               free_len[k] -= aligned;
               len = aligned;
            end else begin
               len = free_len[k];
               remove_seg(k);
            end
            g = '{status: ffra_pkg::ST_OK, offset: off[ffra_pkg::ADDR_W-1:0],
                  size: len[ffra_pkg::SIZE_W-1:0]};
            return g;
         end
      end
      return g;
   endfunction

   function automatic logic [1:0] return_range(longint unsigned off, longint unsigned len);
      longint unsigned fin;
      int  k;
      bit  join_lo, join_hi;
      fin = off + len;
      k = 0;
      if (len == 0 || fin > pool_len) return ffra_pkg::ST_INVALID;
      while (k < free_count && free_start[k] < off) k++;
      if (k > 0 && free_start[k-1] + free_len[k-1] > off) return ffra_pkg::ST_INVALID;
      if (k < free_count && fin > free_start[k]) return ffra_pkg::ST_INVALID;
      join_lo = k > 0 && free_start[k-1] + free_len[k-1] == off;
      join_hi = k < free_count && fin == free_start[k];
      if (join_lo && join_hi) begin
         free_len[k-1] += len + free_len[k];
         remove_seg(k);
      end else if (join_lo) begin
         free_len[k-1] += len;
      end else if (join_hi) begin
         free_start[k] = off;
         free_len[k] += len;
      end else begin
         if (free_count >= ffra_pkg::SEG_DEPTH) return ffra_pkg::ST_FULL;
         for (int j = free_count; j > k; j--) begin
            free_start[j] = free_start[j-1];
            free_len[j] = free_len[j-1];
         end
         free_start[k] = off;
         free_len[k] = len;
         free_count++;
      end
      return ffra_pkg::ST_OK;
   endfunction

   // drive one item, wait for its accept, then predict
   task automatic send_item(logic op, logic [ffra_pkg::SIZE_W-1:0] size,
                            logic [ffra_pkg::ADDR_W-1:0] off);
      grant_type g;
      start <= 1'b1;
      req_operation <= op;
      req_request_size <= size;
      req_block_offset <= off;
      do @(posedge clock); while (busy);
      if (op == ffra_pkg::OP_ALLOC) begin
         g = allocate_range(longint'(size));
         if (g.status == ffra_pkg::ST_OK && g.size != 0) begin
            held_off.push_back(longint'(g.offset));
            held_len.push_back(longint'(g.size));
         end
      end else begin
         g = '{status: return_range(longint'(off), longint'(size)), offset: '0, size: '0};
      end
      pending_grants.push_back(g);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold until every result is in and the table shift is done
   task automatic drain();
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [ffra_pkg::SIZE_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ffra_pkg::CSR_POOL) begin
         pool_len = (longint'(value) > longint'(ffra_pkg::POOL_MAX))
                    ? longint'(ffra_pkg::POOL_MAX) : longint'(value);
         clear_table();
         held_off.delete();
         held_len.delete();
      end else begin
         align_sh = value[4:0];
      end
   endtask

   // return a random held grant
   task automatic free_held();
      int k;
      k = $urandom_range(held_off.size() - 1);
      send_item(ffra_pkg::OP_FREE, held_len[k][ffra_pkg::SIZE_W-1:0],
                held_off[k][ffra_pkg::ADDR_W-1:0]);
      held_off.delete(k);
      held_len.delete(k);
   endtask

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, rsp_status);
            errors++;
         end else begin
            grant_type g;
            g = pending_grants.pop_front();
            if (rsp_status !== g.status) begin
               $display("%0t: status exp %0d got %0d", $time, g.status, rsp_status);
               errors++;
            end
            if (rsp_granted_offset !== g.offset) begin
               $display("%0t: offset exp %0h got %0h", $time, g.offset, rsp_granted_offset);
               errors++;
            end
            if (rsp_granted_size !== g.size) begin
               $display("%0t: size exp %0h got %0h", $time, g.size, rsp_granted_size);
               errors++;
            end
         end
      end
   end

   task automatic test_empty_pool();
      send_item(ffra_pkg::OP_ALLOC, '0, '0);
      send_item(ffra_pkg::OP_ALLOC, 33'd5, '0);
      send_item(ffra_pkg::OP_FREE, 33'd1, '0);
   endtask

   task automatic test_split_merge();
      write_csr(ffra_pkg::CSR_POOL, 33'd1000);
      write_csr(ffra_pkg::CSR_ALIGN, 33'd0);
      send_item(ffra_pkg::OP_ALLOC, '0, '0);             // zero-length allocate
      send_item(ffra_pkg::OP_ALLOC, 33'd100, '0);
      send_item(ffra_pkg::OP_ALLOC, 33'd100, '0);
      send_item(ffra_pkg::OP_ALLOC, 33'd100, '0);
      send_item(ffra_pkg::OP_FREE, '0, 32'd10);          // zero-length free
      send_item(ffra_pkg::OP_FREE, 33'd10, 32'd995);     // runs past the pool
      send_item(ffra_pkg::OP_FREE, 33'd50, 32'd280);     // overlaps free space
      send_item(ffra_pkg::OP_FREE, 33'd100, 32'd0);      // isolated insert
      send_item(ffra_pkg::OP_FREE, 33'd100, 32'd200);    // joins the tail
      send_item(ffra_pkg::OP_FREE, 33'd100, 32'd100);    // joins both sides
      send_item(ffra_pkg::OP_ALLOC, 33'd2000, '0);       // no fit
      send_item(ffra_pkg::OP_ALLOC, 33'd1000, '0);       // whole pool
      send_item(ffra_pkg::OP_ALLOC, 33'd1, '0);          // empty table
      send_item(ffra_pkg::OP_FREE, 33'd1000, 32'd0);
   endtask

   task automatic test_alignment();
      write_csr(ffra_pkg::CSR_POOL, 33'd10);
      write_csr(ffra_pkg::CSR_ALIGN, 33'd4);
      send_item(ffra_pkg::OP_ALLOC, 33'd9, '0);          // fits unaligned only: whole segment
      send_item(ffra_pkg::OP_FREE, 33'd10, 32'd0);
      send_item(ffra_pkg::OP_ALLOC, 33'd3, '0);
      write_csr(ffra_pkg::CSR_POOL, 33'h1_FFFF_FFFF);    // saturates
      write_csr(ffra_pkg::CSR_ALIGN, 33'd31);
      send_item(ffra_pkg::OP_ALLOC, 33'd1, '0);
      send_item(ffra_pkg::OP_ALLOC, 33'h1_FFFF_FFFF, '0);
      send_item(ffra_pkg::OP_ALLOC, 33'h1_0000_0000, '0);
      send_item(ffra_pkg::OP_FREE, 33'd1, 32'hFFFF_FFFF);
      send_item(ffra_pkg::OP_FREE, 33'h1_0000_0000, 32'd0);
      send_item(ffra_pkg::OP_ALLOC, 33'h1_0000_0000, '0);
   endtask

   task automatic test_table_full();
      write_csr(ffra_pkg::CSR_POOL, 33'd256);
      write_csr(ffra_pkg::CSR_ALIGN, 33'd0);
      for (int k = 0; k < 128; k++) send_item(ffra_pkg::OP_ALLOC, 33'd1, '0);
      for (int k = 0; k < 126; k += 2) begin
         send_item(ffra_pkg::OP_FREE, 33'd1, k[ffra_pkg::ADDR_W-1:0]);
      end
      send_item(ffra_pkg::OP_FREE, 33'd1, 32'd126);      // no neighbor, table full
      send_item(ffra_pkg::OP_FREE, 33'd1, 32'd1);        // merges both sides
      send_item(ffra_pkg::OP_FREE, 33'd1, 32'd126);
   endtask

   // mostly alloc/free of held grants, some noise
   task automatic test_random(int count, longint unsigned pool, int unsigned sh, bit wide);
      longint unsigned lim;
      int pick;
      write_csr(ffra_pkg::CSR_POOL, pool[ffra_pkg::SIZE_W-1:0]);
      write_csr(ffra_pkg::CSR_ALIGN, ffra_pkg::SIZE_W'(sh));
      lim = (pool > 8) ? pool / 8 : 1;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_item(logic'($urandom_range(1)), {1'($urandom), 32'($urandom)},
                      32'($urandom));
         end else if (pick < 55 && held_off.size() != 0) begin
            free_held();
         end else if (wide) begin
            send_item(ffra_pkg::OP_ALLOC, {1'b0, 32'($urandom)} >> $urandom_range(31), '0);
         end else begin
            send_item(ffra_pkg::OP_ALLOC,
                      ffra_pkg::SIZE_W'($urandom_range(0, int'(lim))), '0);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      pool_len = 0;
      align_sh = 0;
      clear_table();
      @(posedge clock);
      test_empty_pool();
      test_split_merge();
      test_alignment();
      test_table_full();
      test_random(60, 1024, 0, 1'b0);
      gap_pct = 0;
      test_random(60, 4096, 2, 1'b0);
      gap_pct = 30;
      test_random(60, 600, 3, 1'b0);
      test_random(60, 64'h1_0000_0000, 31, 1'b1);
      test_random(60, 64'h1_0000_0000, 0, 1'b1);
      drain();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
